### design/line_clip_rectangle_core_macros.svh
// assertion macros for the line clipper core
// needs clk and rst_n in the scope where they are used
`ifndef LINE_CLIP_RECTANGLE_CORE_MACROS_SVH
`define LINE_CLIP_RECTANGLE_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LCR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line clipper check failed");

// condition never holds
`define LCR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("line clipper check failed");

`endif

### design/lcr_pkg.sv
// shared types, widths and constants of the line clipper
// no dependencies
package lcr_pkg;

  localparam int COORD_W    = 24;
  localparam int COORD_FRAC = 8;
  localparam int T_FRAC     = 16;
  localparam int MAX_DIM    = 2048;
  localparam int DIM_W      = 12;
  localparam int EDGE_W     = $clog2(MAX_DIM) + COORD_FRAC;
  localparam int D_W        = COORD_W + 1;
  localparam int VAL_W      = COORD_W + 2;
  localparam int REM_W      = VAL_W + 1;
  localparam int Q_BITS     = T_FRAC + 1;
  localparam int T_W        = T_FRAC + 3;
  localparam int PROD_W     = D_W + T_W;

  localparam int DIV_PER_STAGE   = 2;
  localparam int DIV_STEP_STAGES = (Q_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int DIV_LAT         = DIV_STEP_STAGES + 2;
  localparam int SEL_LAT         = 2;
  localparam int SCALE_LAT       = 2;
  localparam int PIPE_LAT        = 1 + DIV_LAT + SEL_LAT + SCALE_LAT;

  localparam logic signed [T_W-1:0] T_ONE = T_W'(1) <<< T_FRAC;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [EDGE_W-1:0] WIDTH_RST_MAX  = EDGE_W'(639) << COORD_FRAC;
  localparam logic [EDGE_W-1:0] HEIGHT_RST_MAX = EDGE_W'(479) << COORD_FRAC;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } lcr_in_t;

  typedef struct packed {
    logic                      visible;
    logic signed [COORD_W-1:0] clip_start_x;
    logic signed [COORD_W-1:0] clip_start_y;
    logic signed [COORD_W-1:0] clip_end_x;
    logic signed [COORD_W-1:0] clip_end_y;
  } lcr_out_t;

  // segment word with its deltas
  typedef struct packed {
    lcr_in_t               pts;
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
  } lcr_seg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] num;
    logic signed [VAL_W-1:0] den;
  } lcr_edge_in_t;

  typedef struct packed {
    logic                  den_zero;
    logic                  den_pos;
    logic                  num_le0;
    logic signed [T_W-1:0] t;
  } lcr_edge_t;

  typedef struct packed {
    logic [REM_W-1:0]  r;
    logic [VAL_W-1:0]  d;
    logic [Q_BITS-1:0] q;
    logic              sat;
    logic              neg;
    logic              den_zero;
    logic              den_pos;
    logic              num_le0;
  } lcr_div_st_t;

  typedef struct packed {
    logic                  vis;
    logic signed [T_W-1:0] t_in;
    logic signed [T_W-1:0] t_out;
  } lcr_tpair_t;

endpackage

### design/line_clip_rectangle_core.sv
// Line clipper against the screen rectangle, one segment word per cycle.
// A word given with start is taken every cycle (busy stays low) and its result
// appears on out_word together with out_valid, which is high for one cycle;
// the receiver cannot stall. The pipeline is made of the pipelined edge dividers
// (two quotient bits per stage, one in the last), the two-stage edge selection and the
// multiply and round stages. Configuration writes apply to words taken after.
// depends on lcr_pkg, lcr_edge_div, lcr_clip_sel, lcr_scale and the macro header
`include "line_clip_rectangle_core_macros.svh"

module line_clip_rectangle_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  lcr_pkg::lcr_in_t                  in_word,
  output logic                              out_valid,
  output lcr_pkg::lcr_out_t                 out_word,
  input  logic                              cfg_we,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcr_pkg::DIM_W-1:0]         cfg_wdata
);

  localparam int SEG_DEPTH = lcr_pkg::DIV_LAT + lcr_pkg::SEL_LAT;

  logic [lcr_pkg::EDGE_W-1:0] max_x_r, max_y_r, dim_max;
  logic [lcr_pkg::DIM_W-1:0]  dim_clamped;
  logic [lcr_pkg::PIPE_LAT-1:0] vld_r;
  lcr_pkg::lcr_seg_t    seg_r [0:SEG_DEPTH];
  lcr_pkg::lcr_seg_t    seg_nxt;
  lcr_pkg::lcr_edge_in_t ein_r [0:3];
  lcr_pkg::lcr_edge_in_t ein_nxt [0:3];
  lcr_pkg::lcr_edge_t   edv [0:3];
  lcr_pkg::lcr_tpair_t  tpair;

  assign busy = 1'b0;

  // clamp written dimension and turn it into an edge coordinate
  always_comb begin
    if (cfg_wdata == '0) dim_clamped = lcr_pkg::DIM_W'(1);
    else if (cfg_wdata > lcr_pkg::DIM_W'(lcr_pkg::MAX_DIM))
      dim_clamped = lcr_pkg::DIM_W'(lcr_pkg::MAX_DIM);
    else dim_clamped = cfg_wdata;
    dim_max = lcr_pkg::EDGE_W'(dim_clamped - lcr_pkg::DIM_W'(1)) << lcr_pkg::COORD_FRAC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r <= lcr_pkg::WIDTH_RST_MAX;
      max_y_r <= lcr_pkg::HEIGHT_RST_MAX;
    end else if (cfg_we) begin
      if (cfg_index == lcr_pkg::CFG_WIDTH) max_x_r <= dim_max;
      else if (cfg_index == lcr_pkg::CFG_HEIGHT) max_y_r <= dim_max;
    end
  end

  // deltas and per edge numerator and denominator
  always_comb begin
    logic signed [lcr_pkg::VAL_W-1:0] x1, y1, x2, y2, mx, my;
    x1 = lcr_pkg::VAL_W'(in_word.start_x);
    y1 = lcr_pkg::VAL_W'(in_word.start_y);
    x2 = lcr_pkg::VAL_W'(in_word.end_x);
    y2 = lcr_pkg::VAL_W'(in_word.end_y);
    mx = lcr_pkg::VAL_W'({1'b0, max_x_r});
    my = lcr_pkg::VAL_W'({1'b0, max_y_r});
    seg_nxt.pts = in_word;
    seg_nxt.dx  = lcr_pkg::D_W'(x2 - x1);
    seg_nxt.dy  = lcr_pkg::D_W'(y2 - y1);
    ein_nxt[0].num = -x1;       ein_nxt[0].den = x2 - x1;
    ein_nxt[1].num = x1 - mx;   ein_nxt[1].den = x1 - x2;
    ein_nxt[2].num = -y1;       ein_nxt[2].den = y2 - y1;
    ein_nxt[3].num = y1 - my;   ein_nxt[3].den = y1 - y2;
  end

  always_ff @(posedge clk) begin
    seg_r[0] <= seg_nxt;
    for (int i = 0; i < 4; i++) ein_r[i] <= ein_nxt[i];
    for (int i = 1; i <= SEG_DEPTH; i++) seg_r[i] <= seg_r[i-1];
  end

  // valid bits travel with the words
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[lcr_pkg::PIPE_LAT-2:0], start};
  end

  assign out_valid = vld_r[lcr_pkg::PIPE_LAT-1];

  for (genvar e = 0; e < 4; e++) begin : g_div
    lcr_edge_div u_div (
      .clk      (clk),
      .edge_in  (ein_r[e]),
      .edge_out (edv[e])
    );
  end

  lcr_clip_sel u_sel (
    .clk   (clk),
    .edge0 (edv[0]),
    .edge1 (edv[1]),
    .edge2 (edv[2]),
    .edge3 (edv[3]),
    .tpair (tpair)
  );

  lcr_scale u_scale (
    .clk      (clk),
    .seg      (seg_r[SEG_DEPTH]),
    .tpair    (tpair),
    .out_word (out_word)
  );

  // checks
  `LCR_ASSERT_NEVER(a_strobe_without_word, out_valid && !$past(start, lcr_pkg::PIPE_LAT))
  `LCR_ASSERT_IMPLY(a_reject_keeps_start, out_valid && !out_word.visible, out_word.clip_start_x == $past(in_word.start_x, lcr_pkg::PIPE_LAT))
  `LCR_ASSERT_IMPLY(a_reject_keeps_end, out_valid && !out_word.visible, out_word.clip_end_y == $past(in_word.end_y, lcr_pkg::PIPE_LAT))

endmodule

### design/lcr_edge_div.sv
// pipelined restoring divider giving the clamped edge parameter t
// depends on lcr_pkg
module lcr_edge_div (
  input  logic                  clk,
  input  lcr_pkg::lcr_edge_in_t edge_in,
  output lcr_pkg::lcr_edge_t    edge_out
);

  lcr_pkg::lcr_div_st_t st_r [0:lcr_pkg::DIV_STEP_STAGES];
  lcr_pkg::lcr_div_st_t prep_nxt;
  lcr_pkg::lcr_edge_t   out_r, out_nxt;
  logic [lcr_pkg::VAL_W-1:0] n_mag, d_mag;

  // magnitudes, sign and overflow check
  always_comb begin
    n_mag = edge_in.num[lcr_pkg::VAL_W-1] ? lcr_pkg::VAL_W'(-edge_in.num)
                                          : lcr_pkg::VAL_W'(edge_in.num);
    d_mag = edge_in.den[lcr_pkg::VAL_W-1] ? lcr_pkg::VAL_W'(-edge_in.den)
                                          : lcr_pkg::VAL_W'(edge_in.den);
    prep_nxt.r        = {1'b0, n_mag};
    prep_nxt.d        = d_mag;
    prep_nxt.q        = '0;
    prep_nxt.sat      = {1'b0, n_mag} >= {d_mag, 1'b0};
    prep_nxt.neg      = edge_in.num[lcr_pkg::VAL_W-1] ^ edge_in.den[lcr_pkg::VAL_W-1];
    prep_nxt.den_zero = (edge_in.den == '0);
    prep_nxt.den_pos  = !edge_in.den[lcr_pkg::VAL_W-1] && (edge_in.den != '0);
    prep_nxt.num_le0  = edge_in.num[lcr_pkg::VAL_W-1] || (edge_in.num == '0);
  end

  always_ff @(posedge clk) begin
    st_r[0] <= prep_nxt;
  end

  // two quotient bits per stage, one in the last stage
  for (genvar s = 0; s < lcr_pkg::DIV_STEP_STAGES; s++) begin : g_step
    lcr_pkg::lcr_div_st_t st_nxt;
    always_comb begin
      logic [lcr_pkg::REM_W-1:0] rr;
      st_nxt = st_r[s];
      for (int j = 0; j < lcr_pkg::DIV_PER_STAGE; j++) begin
        if (s * lcr_pkg::DIV_PER_STAGE + j < lcr_pkg::Q_BITS) begin
          rr = (s * lcr_pkg::DIV_PER_STAGE + j == 0) ? st_nxt.r : (st_nxt.r << 1);
          if (rr >= {1'b0, st_nxt.d}) begin
            st_nxt.r = rr - {1'b0, st_nxt.d};
            st_nxt.q = {st_nxt.q[lcr_pkg::Q_BITS-2:0], 1'b1};
          end else begin
            st_nxt.r = rr;
            st_nxt.q = {st_nxt.q[lcr_pkg::Q_BITS-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      st_r[s+1] <= st_nxt;
    end
  end

  // saturate and apply sign, truncation toward zero
  always_comb begin
    logic [lcr_pkg::Q_BITS-1:0] qm;
    logic signed [lcr_pkg::T_W-1:0] tm;
    qm = st_r[lcr_pkg::DIV_STEP_STAGES].sat ? '1 : st_r[lcr_pkg::DIV_STEP_STAGES].q;
    tm = lcr_pkg::T_W'({2'b00, qm});
    out_nxt.den_zero = st_r[lcr_pkg::DIV_STEP_STAGES].den_zero;
    out_nxt.den_pos  = st_r[lcr_pkg::DIV_STEP_STAGES].den_pos;
    out_nxt.num_le0  = st_r[lcr_pkg::DIV_STEP_STAGES].num_le0;
    out_nxt.t        = st_r[lcr_pkg::DIV_STEP_STAGES].neg ? -tm : tm;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign edge_out = out_r;

endmodule

### design/lcr_clip_sel.sv
// narrows entering and leaving parameters over the left, right, bottom and top edges
// depends on lcr_pkg
module lcr_clip_sel (
  input  logic               clk,
  input  lcr_pkg::lcr_edge_t edge0,
  input  lcr_pkg::lcr_edge_t edge1,
  input  lcr_pkg::lcr_edge_t edge2,
  input  lcr_pkg::lcr_edge_t edge3,
  output lcr_pkg::lcr_tpair_t tpair
);

  function automatic lcr_pkg::lcr_tpair_t edge_upd(lcr_pkg::lcr_tpair_t p,
                                                   lcr_pkg::lcr_edge_t e);
    lcr_pkg::lcr_tpair_t n;
    n = p;
    if (e.den_zero) begin
      n.vis = p.vis && e.num_le0;
    end else if (e.den_pos) begin
      if (e.t > p.t_out) n.vis = 1'b0;
      else if (e.t > p.t_in) n.t_in = e.t;
    end else begin
      if (e.t < p.t_in) n.vis = 1'b0;
      else if (e.t < p.t_out) n.t_out = e.t;
    end
    return n;
  endfunction

  lcr_pkg::lcr_tpair_t a_r, a_nxt, b_r, b_nxt, p0;
  lcr_pkg::lcr_edge_t  e2_r, e3_r;

  // left and right edges
  always_comb begin
    p0.vis   = 1'b1;
    p0.t_in  = '0;
    p0.t_out = lcr_pkg::T_ONE;
    a_nxt    = edge_upd(edge_upd(p0, edge0), edge1);
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    e2_r <= edge2;
    e3_r <= edge3;
  end

  // bottom and top edges
  assign b_nxt = edge_upd(edge_upd(a_r, e2_r), e3_r);

  always_ff @(posedge clk) begin
    b_r <= b_nxt;
  end

  assign tpair = b_r;

endmodule

### design/lcr_scale.sv
// moves the endpoints along the segment by the final parameters
// depends on lcr_pkg
module lcr_scale (
  input  logic                clk,
  input  lcr_pkg::lcr_seg_t   seg,
  input  lcr_pkg::lcr_tpair_t tpair,
  output lcr_pkg::lcr_out_t   out_word
);

  localparam logic signed [lcr_pkg::PROD_W-1:0] HALF =
    lcr_pkg::PROD_W'(1) <<< (lcr_pkg::T_FRAC - 1);

  logic signed [lcr_pkg::PROD_W-1:0] px_out_r, py_out_r, px_in_r, py_in_r;
  lcr_pkg::lcr_seg_t   seg_r;
  lcr_pkg::lcr_tpair_t tp_r;
  lcr_pkg::lcr_out_t   out_r, out_nxt;

  function automatic logic [lcr_pkg::COORD_W-1:0] place(
      logic signed [lcr_pkg::COORD_W-1:0] base, logic signed [lcr_pkg::PROD_W-1:0] p);
    logic signed [lcr_pkg::PROD_W-1:0] s;
    s = (p + HALF) >>> lcr_pkg::T_FRAC;
    return base + s[lcr_pkg::COORD_W-1:0];
  endfunction

  // products of delta and parameter
  always_ff @(posedge clk) begin
    px_out_r <= lcr_pkg::PROD_W'(seg.dx * tpair.t_out);
    py_out_r <= lcr_pkg::PROD_W'(seg.dy * tpair.t_out);
    px_in_r  <= lcr_pkg::PROD_W'(seg.dx * tpair.t_in);
    py_in_r  <= lcr_pkg::PROD_W'(seg.dy * tpair.t_in);
    seg_r    <= seg;
    tp_r     <= tpair;
  end

  // round, offset and select
  always_comb begin
    out_nxt.visible      = tp_r.vis;
    out_nxt.clip_start_x = seg_r.pts.start_x;
    out_nxt.clip_start_y = seg_r.pts.start_y;
    out_nxt.clip_end_x   = seg_r.pts.end_x;
    out_nxt.clip_end_y   = seg_r.pts.end_y;
    if (tp_r.vis && (tp_r.t_out < lcr_pkg::T_ONE)) begin
      out_nxt.clip_end_x = place(seg_r.pts.start_x, px_out_r);
      out_nxt.clip_end_y = place(seg_r.pts.start_y, py_out_r);
    end
    if (tp_r.vis && (tp_r.t_in > 0)) begin
      out_nxt.clip_start_x = place(seg_r.pts.start_x, px_in_r);
      out_nxt.clip_start_y = place(seg_r.pts.start_y, py_in_r);
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_word = out_r;

endmodule
